>>> src/sliding_window_working_set_counter_macros.svh
// assertion macros shared by the working-set counter checkers
// no dependencies; clk and rst are taken from the including scope
`ifndef SLIDING_WINDOW_WORKING_SET_COUNTER_MACROS_SVH
`define SLIDING_WINDOW_WORKING_SET_COUNTER_MACROS_SVH

// same-cycle implication, masked during reset
`define SWWSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define SWWSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, also checked across reset
`define SWWSC_ASSERT_NXT_ANY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/swwsc_pkg.sv
// shared constants, types and helpers for the working-set counter
// no dependencies
package swwsc_pkg;

  localparam int ADDR_BITS      = 20;
  localparam int WINDOW_DEPTH   = 4096;
  localparam int MIN_PAGE_SHIFT = 4;
  localparam int MAX_PAGE_SHIFT = 16;

  localparam int PAGE_BITS  = 16;
  localparam int PAGE_COUNT = 65536;
  localparam int SLOT_BITS  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_BITS  = $clog2(WINDOW_DEPTH + 1);
  localparam int CNT_BITS   = 13;
  localparam int WIN_BITS   = 13;
  localparam int SHIFT_BITS = 5;

  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 13;

  localparam logic [WIN_BITS-1:0]   WINDOW_SIZE_RST = 13'd4096;
  localparam logic [SHIFT_BITS-1:0] PAGE_SHIFT_RST  = 5'd12;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WINDOW_SIZE  = 2'd0,
    REG_PAGE_SHIFT   = 2'd1,
    REG_IGNORE_INSTR = 2'd2
  } cfg_reg_t;

  // result queue depth and credit counter
  localparam int OUT_DEPTH    = 4;
  localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
  localparam int CREDIT_BITS  = $clog2(OUT_DEPTH + 1);

  // one read-modify-write of the page count store
  typedef struct packed {
    logic                 vld;
    logic                 inc;
    logic [PAGE_BITS-1:0] page;
  } cnt_op_t;

  // circular slot arithmetic, off never exceeds the depth
  function automatic logic [SLOT_BITS-1:0] slot_add(
    input logic [SLOT_BITS-1:0] base,
    input logic [FILL_BITS-1:0] off
  );
    logic [FILL_BITS:0] s;
    s = (FILL_BITS + 1)'(base) + (FILL_BITS + 1)'(off);
    if (s >= (FILL_BITS + 1)'(WINDOW_DEPTH)) begin
      s = s - (FILL_BITS + 1)'(WINDOW_DEPTH);
    end
    return SLOT_BITS'(s);
  endfunction

endpackage

>>> src/sliding_window_working_set_counter.sv
// sliding-window working-set counter, top level; uses swwsc_pkg and swwsc_ram
// a counted access passes p, s1 and the result queue; one that evicts also passes q
// in_ready is low while stage p holds an access, set by the single read port of the
// page count ram (one read-modify-write for the eviction, one for the new page)
// dropped fetches leave in_ready high; after reset a clearing pass zeroes the
// count ram, during which in_ready stays low (configuration writes still taken)
module sliding_window_working_set_counter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swwsc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [swwsc_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [swwsc_pkg::ADDR_BITS-1:0]     access_address,
  input  logic                                is_instruction,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [swwsc_pkg::CNT_BITS-1:0]      unique_pages
);

  // configuration
  logic [swwsc_pkg::WIN_BITS-1:0]   window_size;
  logic [swwsc_pkg::SHIFT_BITS-1:0] page_shift;
  logic                             drop_fetches;

  // clearing pass
  logic                             clear_active;
  logic [swwsc_pkg::PAGE_BITS-1:0]  clear_addr;

  // window fifo bookkeeping
  logic [swwsc_pkg::SLOT_BITS-1:0]  fifo_head;
  logic [swwsc_pkg::FILL_BITS-1:0]  fill_count;
  logic [swwsc_pkg::PAGE_BITS-1:0]  fifo_rdata;
  logic [swwsc_pkg::SLOT_BITS-1:0]  tail_slot;

  // accept stage
  logic                             in_take;
  logic                             take;
  logic [swwsc_pkg::FILL_BITS-1:0]  win_eff;
  logic [swwsc_pkg::SHIFT_BITS-1:0] sh_eff;
  logic [swwsc_pkg::PAGE_BITS-1:0]  page;
  logic                             evict;

  // issue stages
  logic                             p_valid;
  logic                             p_evict;
  logic [swwsc_pkg::PAGE_BITS-1:0]  p_page;
  logic                             q_valid;
  logic [swwsc_pkg::PAGE_BITS-1:0]  q_page;
  swwsc_pkg::cnt_op_t               issue_op;

  // count update stage
  swwsc_pkg::cnt_op_t               s1;
  logic [swwsc_pkg::CNT_BITS-1:0]   cnt_rdata;
  logic [swwsc_pkg::CNT_BITS-1:0]   cnt_cur;
  logic [swwsc_pkg::CNT_BITS-1:0]   cnt_new;
  logic                             fwd_valid;
  logic [swwsc_pkg::PAGE_BITS-1:0]  fwd_page;
  logic [swwsc_pkg::CNT_BITS-1:0]   fwd_cnt;
  logic [swwsc_pkg::CNT_BITS-1:0]   distinct_total;
  logic [swwsc_pkg::CNT_BITS-1:0]   distinct_total_next;
  logic                             cnt_we;
  logic [swwsc_pkg::PAGE_BITS-1:0]  cnt_waddr;
  logic [swwsc_pkg::CNT_BITS-1:0]   cnt_wdata;

  // result queue
  logic [swwsc_pkg::CNT_BITS-1:0]     oq_data [swwsc_pkg::OUT_DEPTH];
  logic [swwsc_pkg::OUT_PTR_BITS-1:0] oq_wr_ptr;
  logic [swwsc_pkg::OUT_PTR_BITS-1:0] oq_rd_ptr;
  logic [swwsc_pkg::CREDIT_BITS-1:0]  oq_count;
  logic [swwsc_pkg::CREDIT_BITS-1:0]  outstanding;
  logic                               oq_push;
  logic                               oq_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= swwsc_pkg::WINDOW_SIZE_RST;
      page_shift   <= swwsc_pkg::PAGE_SHIFT_RST;
      drop_fetches <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        swwsc_pkg::REG_WINDOW_SIZE: begin
          window_size <= cfg_data[swwsc_pkg::WIN_BITS-1:0];
        end
        swwsc_pkg::REG_PAGE_SHIFT: begin
          page_shift <= cfg_data[swwsc_pkg::SHIFT_BITS-1:0];
        end
        swwsc_pkg::REG_IGNORE_INSTR: begin
          drop_fetches <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- accept
  assign in_ready = !clear_active && !p_valid
                    && (outstanding < swwsc_pkg::CREDIT_BITS'(swwsc_pkg::OUT_DEPTH));
  assign in_take  = in_valid && in_ready;
  assign take     = in_take && !(drop_fetches && is_instruction);

  always_comb begin
    if (window_size == '0) begin
      win_eff = swwsc_pkg::FILL_BITS'(1);
    end else if (32'(window_size) > swwsc_pkg::WINDOW_DEPTH) begin
      win_eff = swwsc_pkg::FILL_BITS'(swwsc_pkg::WINDOW_DEPTH);
    end else begin
      win_eff = swwsc_pkg::FILL_BITS'(window_size);
    end
  end

  always_comb begin
    if (page_shift < swwsc_pkg::SHIFT_BITS'(swwsc_pkg::MIN_PAGE_SHIFT)) begin
      sh_eff = swwsc_pkg::SHIFT_BITS'(swwsc_pkg::MIN_PAGE_SHIFT);
    end else if (page_shift > swwsc_pkg::SHIFT_BITS'(swwsc_pkg::MAX_PAGE_SHIFT)) begin
      sh_eff = swwsc_pkg::SHIFT_BITS'(swwsc_pkg::MAX_PAGE_SHIFT);
    end else begin
      sh_eff = page_shift;
    end
  end

  assign page  = swwsc_pkg::PAGE_BITS'(access_address >> sh_eff);
  assign evict = (fill_count >= win_eff);
  // new page lands at head + fill, also when the oldest leaves this beat
  assign tail_slot = swwsc_pkg::slot_add(fifo_head, fill_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_head  <= '0;
      fill_count <= '0;
    end else if (take) begin
      if (evict) begin
        fifo_head <= swwsc_pkg::slot_add(fifo_head, swwsc_pkg::FILL_BITS'(1));
      end else begin
        fill_count <= fill_count + swwsc_pkg::FILL_BITS'(1);
      end
    end
  end

  // oldest page is read every cycle; a full fifo reads it before the overwrite
  swwsc_ram #(
    .WIDTH (swwsc_pkg::PAGE_BITS),
    .DEPTH (swwsc_pkg::WINDOW_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (take),
    .waddr (tail_slot),
    .wdata (page),
    .raddr (fifo_head),
    .rdata (fifo_rdata)
  );

  // ---------------------------------------------------------------- issue
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      q_valid <= 1'b0;
    end else begin
      p_valid <= take;
      q_valid <= p_valid && p_evict;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p_evict <= evict;
      p_page  <= page;
    end
    q_page <= p_page;
  end

  always_comb begin
    issue_op = '0;
    priority if (q_valid) begin
      issue_op.vld  = 1'b1;
      issue_op.inc  = 1'b1;
      issue_op.page = q_page;
    end else if (p_valid) begin
      issue_op.vld  = 1'b1;
      issue_op.inc  = !p_evict;
      issue_op.page = p_evict ? fifo_rdata : p_page;
    end
  end

  // ---------------------------------------------------------------- count update
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else begin
      s1 <= issue_op;
    end
  end

  // the write of the previous beat is not yet visible in the ram read
  assign cnt_cur = (fwd_valid && fwd_page == s1.page) ? fwd_cnt : cnt_rdata;

  always_comb begin
    cnt_new             = cnt_cur;
    distinct_total_next = distinct_total;
    if (s1.vld) begin
      if (s1.inc) begin
        if (cnt_cur == '0 && distinct_total < swwsc_pkg::CNT_MAX) begin
          distinct_total_next = distinct_total + swwsc_pkg::CNT_BITS'(1);
        end
        if (cnt_cur < swwsc_pkg::CNT_MAX) begin
          cnt_new = cnt_cur + swwsc_pkg::CNT_BITS'(1);
        end
      end else if (cnt_cur != '0) begin
        cnt_new = cnt_cur - swwsc_pkg::CNT_BITS'(1);
        if (cnt_cur == swwsc_pkg::CNT_BITS'(1) && distinct_total != '0) begin
          distinct_total_next = distinct_total - swwsc_pkg::CNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      distinct_total <= '0;
      fwd_valid      <= 1'b0;
      clear_active   <= 1'b1;
      clear_addr     <= '0;
    end else begin
      distinct_total <= distinct_total_next;
      fwd_valid      <= s1.vld;
      if (clear_active) begin
        clear_addr <= clear_addr + swwsc_pkg::PAGE_BITS'(1);
        if (clear_addr == '1) begin
          clear_active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_page <= s1.page;
    fwd_cnt  <= cnt_new;
  end

  assign cnt_we    = clear_active || s1.vld;
  assign cnt_waddr = clear_active ? clear_addr : s1.page;
  assign cnt_wdata = clear_active ? '0 : cnt_new;

  swwsc_ram #(
    .WIDTH (swwsc_pkg::CNT_BITS),
    .DEPTH (swwsc_pkg::PAGE_COUNT)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (issue_op.page),
    .rdata (cnt_rdata)
  );

  // ---------------------------------------------------------------- result queue
  assign oq_push      = s1.vld && s1.inc;
  assign out_valid    = (oq_count != '0);
  assign oq_pop       = out_valid && out_ready;
  assign unique_pages = oq_data[oq_rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr_ptr   <= '0;
      oq_rd_ptr   <= '0;
      oq_count    <= '0;
      outstanding <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_ptr <= oq_wr_ptr + swwsc_pkg::OUT_PTR_BITS'(1);
      end
      if (oq_pop) begin
        oq_rd_ptr <= oq_rd_ptr + swwsc_pkg::OUT_PTR_BITS'(1);
      end
      oq_count <= oq_count + swwsc_pkg::CREDIT_BITS'(oq_push)
                           - swwsc_pkg::CREDIT_BITS'(oq_pop);
      // credits reserve a queue slot for every counted beat in flight
      outstanding <= outstanding + swwsc_pkg::CREDIT_BITS'(take)
                                 - swwsc_pkg::CREDIT_BITS'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_data[oq_wr_ptr] <= distinct_total_next;
    end
  end

endmodule

>>> src/swwsc_ram.sv
// generic simple dual-port ram, one write and one registered read port
// read returns the old contents when the same entry is written that cycle
module swwsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/swwsc_checker.sv
// port-level checks for the working-set counter, bound to the top level
// uses swwsc_pkg and the macros header
`include "sliding_window_working_set_counter_macros.svh"

module swwsc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           is_instruction,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [swwsc_pkg::CNT_BITS-1:0] unique_pages
);

  `SWWSC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(unique_pages), "result dropped or changed while stalled")
  `SWWSC_ASSERT_NXT_ANY(a_clear_after_reset, rst, !in_ready, "input ready during count clearing")
  `SWWSC_ASSERT_NXT(a_data_beat_spacing, in_valid && in_ready && !is_instruction, !in_ready, "data beat followed by accept in next cycle")
  `SWWSC_ASSERT_IMP(a_total_bound, out_valid, 32'(unique_pages) <= swwsc_pkg::WINDOW_DEPTH, "distinct page total exceeds window depth")

endmodule

bind sliding_window_working_set_counter swwsc_checker u_swwsc_checker (.*);
